// ----- hdl/gnss_command_frame_builder_unit_assert.svh -----
// Assertion macros used by the frame builder serialiser.
`ifndef GNSS_COMMAND_FRAME_BUILDER_UNIT_ASSERT_SVH
`define GNSS_COMMAND_FRAME_BUILDER_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define GCFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds, reset included.
`define GCFB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) !(cond)) else $error(msg);

`endif

// ----- hdl/gcfb_pkg.sv -----
`default_nettype none

package gcfb_pkg;

  typedef enum logic {
    OP_RESET = 1'b0,
    OP_SLEEP = 1'b1
  } op_t;

  localparam int FRAME_BYTES = 13;
  localparam int IDX_W       = 4;

  localparam logic [7:0] SYNC_A     = 8'hF1;
  localparam logic [7:0] SYNC_B     = 8'hD9;
  localparam logic [7:0] CLASS_CMD  = 8'h06;
  localparam logic [7:0] ID_RESET   = 8'h40;
  localparam logic [7:0] ID_SLEEP   = 8'h41;
  localparam logic [7:0] PLEN_RESET = 8'h01;
  localparam logic [7:0] PLEN_SLEEP = 8'h05;

  localparam logic [IDX_W-1:0] RESET_BODY_END = 4'd7;
  localparam logic [IDX_W-1:0] SLEEP_BODY_END = 4'd11;
  localparam logic [IDX_W-1:0] RESET_LAST_IDX = 4'd8;
  localparam logic [IDX_W-1:0] SLEEP_LAST_IDX = 4'd12;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]            last_idx;
  } frame_t;

  function automatic frame_t build_frame(input op_t kind, input logic [7:0] rtype,
                                         input logic [31:0] ms, input logic [7:0] action);
    frame_t           f;
    logic [7:0]       ck_a;
    logic [7:0]       ck_b;
    logic [IDX_W-1:0] body_end;
    f        = '0;
    ck_a     = '0;
    ck_b     = '0;
    f.bytes[0] = SYNC_A;
    f.bytes[1] = SYNC_B;
    f.bytes[2] = CLASS_CMD;
    f.bytes[5] = 8'h00;
    if (kind == OP_SLEEP) begin
      f.bytes[3]  = ID_SLEEP;
      f.bytes[4]  = PLEN_SLEEP;
      f.bytes[6]  = ms[7:0];
      f.bytes[7]  = ms[15:8];
      f.bytes[8]  = ms[23:16];
      f.bytes[9]  = ms[31:24];
      f.bytes[10] = action;
      body_end    = SLEEP_BODY_END;
      f.last_idx  = SLEEP_LAST_IDX;
    end else begin
      f.bytes[3]  = ID_RESET;
      f.bytes[4]  = PLEN_RESET;
      f.bytes[6]  = rtype;
      body_end    = RESET_BODY_END;
      f.last_idx  = RESET_LAST_IDX;
    end
    for (int i = 2; i < 11; i++) begin
      if (IDX_W'(i) < body_end) begin
        ck_a = ck_a + f.bytes[i];
        ck_b = ck_b + ck_a;
      end
    end
    if (kind == OP_SLEEP) begin
      f.bytes[11] = ck_a;
      f.bytes[12] = ck_b;
    end else begin
      f.bytes[7] = ck_a;
      f.bytes[8] = ck_b;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gcfb_frame_build.sv -----
`default_nettype none

module gcfb_frame_build (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            op,
  input  wire logic [7:0]      reset_type,
  input  wire logic [31:0]     sleep_time_ms,
  input  wire logic [7:0]      sleep_action,
  output logic                 frame_valid,
  input  wire logic            frame_ready,
  output gcfb_pkg::frame_t     frame
);

  logic        a_valid;
  logic        a_op;
  logic [7:0]  a_type;
  logic [31:0] a_ms;
  logic [7:0]  a_action;

  assign in_ready = !a_valid || frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  // hold the request until the frame stage takes it
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_op     <= op;
      a_type   <= reset_type;
      a_ms     <= sleep_time_ms;
      a_action <= sleep_action;
    end
  end

  assign frame_valid = a_valid;
  assign frame = gcfb_pkg::build_frame(gcfb_pkg::op_t'(a_op), a_type, a_ms, a_action);

endmodule

`default_nettype wire

// ----- hdl/gcfb_serialiser.sv -----
`default_nettype none

module gcfb_serialiser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              frame_valid,
  output logic                   frame_ready,
  input  wire gcfb_pkg::frame_t  frame,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             frame_byte,
  output logic                   last_byte
);

  `include "gnss_command_frame_builder_unit_assert.svh"

  logic                       f_valid;
  gcfb_pkg::frame_t           f;
  logic [gcfb_pkg::IDX_W-1:0] idx;
  logic [gcfb_pkg::IDX_W-1:0] idx_next;
  logic                       o_valid;
  logic [7:0]                 o_byte;
  logic                       o_last;
  logic                       load;
  logic                       at_end;

  assign load        = f_valid && (!o_valid || out_ready);
  assign at_end      = (idx == f.last_idx);
  assign frame_ready = !f_valid || (load && at_end);

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = at_end ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      o_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (frame_ready) begin
        f_valid <= frame_valid;
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ready && frame_valid) begin
      f <= frame;
    end
    if (load) begin
      o_byte <= f.bytes[idx];
      o_last <= at_end;
    end
  end

  assign out_valid  = o_valid;
  assign frame_byte = o_byte;
  assign last_byte  = o_last;

  `GCFB_ASSERT(a_idx_in_frame, f_valid |-> idx <= f.last_idx, "byte index past frame end")
  `GCFB_ASSERT(a_wrap_after_last, (load && at_end) |=> idx == '0,
               "index did not wrap after last byte")
  `GCFB_ASSERT(a_frame_starts_sync, (load && idx == '0) |=> frame_byte == gcfb_pkg::SYNC_A,
               "frame does not open with sync byte")
  `GCFB_ASSERT(a_frame_length, f_valid |->
               (f.last_idx == gcfb_pkg::RESET_LAST_IDX || f.last_idx == gcfb_pkg::SLEEP_LAST_IDX),
               "held frame has an unknown length")
  `GCFB_ASSERT_NEVER(a_idle_index, !rst && !f_valid && idx != '0, "index moved with no frame held")

endmodule

`default_nettype wire

// ----- hdl/gnss_command_frame_builder_unit.sv -----
// Binary command frame builder.
// Input channel (in_valid/in_ready) carries one command request: op selects a
// reset frame (9 bytes, carries reset_type) or a sleep frame (13 bytes, carries
// sleep_time_ms little-endian and sleep_action). Fields the op does not use
// are ignored.
// Output channel (out_valid/out_ready) carries the frame one byte per
// transaction on frame_byte; last_byte marks the second checksum byte.
// The request is held in an input register, the whole frame with its Fletcher
// checksum is built in one pass into a frame register, and a byte counter
// feeds an output register.
// The request passes the input register and the frame register before its first
// byte reaches the output register, which sends one byte per cycle while
// out_ready is high; frames follow each other with no gap.
// A stalled receiver holds the current byte; up to two further requests are
// taken meanwhile, then in_ready drops.
// Reset clears all valid flags and the byte counter, dropping any frame in
// flight; no frame is started until the first request after reset.
`default_nettype none

module gnss_command_frame_builder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  reset_type,
  input  wire logic [31:0] sleep_time_ms,
  input  wire logic [7:0]  sleep_action,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_byte,
  output logic             last_byte
);

  logic             frame_valid;
  logic             frame_ready;
  gcfb_pkg::frame_t frame;

  gcfb_frame_build u_build (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .reset_type    (reset_type),
    .sleep_time_ms (sleep_time_ms),
    .sleep_action  (sleep_action),
    .frame_valid   (frame_valid),
    .frame_ready   (frame_ready),
    .frame         (frame)
  );

  gcfb_serialiser u_serialiser (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

endmodule

`default_nettype wire

// ----- dv/gnss_command_frame_builder_unit_tb.sv -----
`default_nettype none

module gnss_command_frame_builder_unit_tb;

  class frame_checker;
    logic [8:0] pending_bytes[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void note_command(gcfb_pkg::op_t kind, logic [7:0] rtype, logic [31:0] ms,
                               logic [7:0] action);
      logic [7:0] body[13];
      int         n;
      logic [7:0] sum_a;
      logic [7:0] sum_b;
      body[0] = gcfb_pkg::SYNC_A;
      body[1] = gcfb_pkg::SYNC_B;
      body[2] = gcfb_pkg::CLASS_CMD;
      body[5] = 8'h00;
      if (kind == gcfb_pkg::OP_SLEEP) begin
        body[3]  = gcfb_pkg::ID_SLEEP;
        body[4]  = gcfb_pkg::PLEN_SLEEP;
        body[6]  = ms[7:0];
        body[7]  = ms[15:8];
        body[8]  = ms[23:16];
        body[9]  = ms[31:24];
        body[10] = action;
        n = 13;
      end else begin
        body[3] = gcfb_pkg::ID_RESET;
        body[4] = gcfb_pkg::PLEN_RESET;
        body[6] = rtype;
        n = 9;
      end
      sum_a = 8'h00;
      sum_b = 8'h00;
      for (int i = 2; i < n - 2; i++) begin
        sum_a = sum_a + body[i];
        sum_b = sum_b + sum_a;
      end
      body[n-2] = sum_a;
      body[n-1] = sum_b;
      for (int i = 0; i < n; i++) begin
        pending_bytes.push_back({(i == n - 1) ? 1'b1 : 1'b0, body[i]});
      end
    endfunction

    function void check_byte(logic [7:0] got, logic got_last);
      logic [8:0] want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                 $time, got, got_last);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want[7:0]) begin
        $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                 $time, want[7:0], got);
        errors++;
      end
      if (got_last !== want[8]) begin
        $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                 $time, want[8], got_last);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  gcfb_pkg::op_t op;
  logic [7:0]    reset_type;
  logic [31:0]   sleep_time_ms;
  logic [7:0]    sleep_action;
  logic          out_valid;
  logic          out_ready;
  logic [7:0]    frame_byte;
  logic          last_byte;

  int           send_idle;
  int           recv_idle;
  frame_checker frames;

  gnss_command_frame_builder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .reset_type    (reset_type),
    .sleep_time_ms (sleep_time_ms),
    .sleep_action  (sleep_action),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        frames.note_command(op, reset_type, sleep_time_ms, sleep_action);
      end
      if (out_valid && out_ready) begin
        frames.check_byte(frame_byte, last_byte);
      end
    end
  end

  task automatic send_command(gcfb_pkg::op_t kind, logic [7:0] rtype, logic [31:0] ms,
                              logic [7:0] action);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    op            = kind;
    reset_type    = rtype;
    sleep_time_ms = ms;
    sleep_action  = action;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [31:0] ms;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0:       ms = 32'h0000_0000;
        1:       ms = 32'hFFFF_FFFF;
        default: ms = $urandom;
      endcase
      send_command(gcfb_pkg::op_t'($urandom_range(1)), 8'($urandom), ms, 8'($urandom));
    end
  endtask

  initial begin
    frames        = new();
    send_idle     = 24;
    recv_idle     = 61;
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = gcfb_pkg::OP_RESET;
    reset_type    = 8'h00;
    sleep_time_ms = 32'h0;
    sleep_action  = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset frames: type extremes, unused sleep fields loaded
    send_command(gcfb_pkg::OP_RESET, 8'h00, 32'h0000_0000, 8'h00);
    send_command(gcfb_pkg::OP_RESET, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(gcfb_pkg::OP_RESET, 8'h55, 32'hDEAD_BEEF, 8'hA5);
    send_command(gcfb_pkg::OP_RESET, 8'hAA, 32'h1234_5678, 8'h5A);
    send_command(gcfb_pkg::OP_RESET, 8'h80, 32'h0, 8'h0);
    send_command(gcfb_pkg::OP_RESET, 8'h01, 32'h0, 8'h0);
    // sleep frames: duration and action extremes, checksum wrap
    send_command(gcfb_pkg::OP_SLEEP, 8'hFF, 32'h0000_0000, 8'h00);
    send_command(gcfb_pkg::OP_SLEEP, 8'h00, 32'hFFFF_FFFF, 8'hFF);
    send_command(gcfb_pkg::OP_SLEEP, 8'h3C, 32'h8000_0000, 8'h01);
    send_command(gcfb_pkg::OP_SLEEP, 8'hC3, 32'h0000_0001, 8'h80);
    send_command(gcfb_pkg::OP_SLEEP, 8'h00, 32'h1234_5678, 8'h9A);
    send_command(gcfb_pkg::OP_SLEEP, 8'h00, 32'hFF00_FF00, 8'h00);
    send_command(gcfb_pkg::OP_SLEEP, 8'h00, 32'h00FF_00FF, 8'hFF);
    // mixed kinds in succession
    send_command(gcfb_pkg::OP_RESET, 8'h7F, 32'h0, 8'h0);
    send_command(gcfb_pkg::OP_SLEEP, 8'h00, 32'h7FFF_FFFF, 8'h7F);
    send_command(gcfb_pkg::OP_RESET, 8'hFE, 32'h0, 8'h0);

    send_random(45);
    send_idle = 61;
    recv_idle = 24;
    send_random(45);
    send_idle = 0;
    recv_idle = 0;
    send_random(45);

    @(negedge clk);
    in_valid = 1'b0;
    while (frames.pending_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (frames.errors == 0 && frames.pending_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
